// ----- sv/wmrs_pkg.sv -----
// Shared widths, limits and saturating helpers for the windowed mean / RMS sum block.
package wmrs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int DEV_W      = 11;
    localparam int SQ_W       = 2 * DEV_W;
    localparam int WSUM_W     = 24;
    localparam int DSUM_W     = 30;
    localparam int M_TDATA_W  = 72;

    localparam logic [DEV_W-1:0] DEV_LIMIT = 11'd2047;

    localparam logic signed [SUM_W+1:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [SUM_W+1:0] SUM_MIN = -34'sd2147483648;

    typedef logic signed [SUM_W-1:0] sum_t;

    function automatic sum_t sat32(input logic signed [SUM_W+1:0] v);
        sum_t r;
        if (v > SUM_MAX) begin
            r = SUM_MAX[SUM_W-1:0];
        end else if (v < SUM_MIN) begin
            r = SUM_MIN[SUM_W-1:0];
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

    // Add then subtract, each step clamped to the 32-bit signed range.
    function automatic sum_t window_update(input sum_t sum, input sum_t add, input sum_t sub);
        sum_t t;
        t = sat32((SUM_W+2)'(sum) + (SUM_W+2)'(add));
        return sat32((SUM_W+2)'(t) - (SUM_W+2)'(sub));
    endfunction

endpackage

// ----- sv/windowed_mean_and_rms_sum.sv -----
// Path: an accepted sample beat passes through stages p1 to p5 and then the output register.
// Throughput: one sample per cycle while the output is not stalled; set by the running-sum update
//   and one read-plus-write port on each of the two ring memories.
// Output stalls freeze the whole pipeline; s_tready follows the output register.
// Reset (aresetn low, synchronous) clears sums, index and valids; the rings are not
//   swept: a wrap flag makes entries not yet written read as zero.
module windowed_mean_and_rms_sum #(
    parameter int WINDOW_LOG2 = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wmrs_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wmrs_pkg::M_TDATA_W-1:0]  m_tdata    // [23:0] window_sum, [39:24] window_mean,
                                                       // [69:40] dev_square_sum, [71:70] zero
);
    import wmrs_pkg::*;

    localparam int DEPTH = 1 << WINDOW_LOG2;
    localparam int IDX_W = WINDOW_LOG2;

    logic signed [SAMPLE_W-1:0] sample_ring [DEPTH];
    logic [SQ_W-1:0]            square_ring [DEPTH];

    logic                 adv;
    logic                 in_beat;
    logic [IDX_W-1:0]     ring_index_reg;
    logic                 filled_reg;
    sum_t                 sample_sum_reg;
    sum_t                 sample_sum_next;
    sum_t                 square_sum_reg;
    sum_t                 square_sum_next;

    // stage 1: ring read data back
    logic                       p1_valid_reg;
    logic signed [SAMPLE_W-1:0] p1_sample_reg;
    logic [IDX_W-1:0]           p1_idx_reg;
    logic                       p1_ok_reg;
    logic signed [SAMPLE_W-1:0] sample_rd_reg;
    // stage 2: updated sum in sample_sum_reg
    logic                       p2_valid_reg;
    logic signed [SAMPLE_W-1:0] p2_sample_reg;
    logic [IDX_W-1:0]           p2_idx_reg;
    logic                       p2_ok_reg;
    // stage 3: clamped deviation
    logic                       p3_valid_reg;
    logic [DEV_W-1:0]           p3_dev_reg;
    logic [WSUM_W-1:0]          p3_wsum_reg;
    logic [SAMPLE_W-1:0]        p3_mean_reg;
    logic [IDX_W-1:0]           p3_idx_reg;
    logic                       p3_ok_reg;
    // stage 4: square
    logic                       p4_valid_reg;
    logic [SQ_W-1:0]            p4_sq_reg;
    logic [WSUM_W-1:0]          p4_wsum_reg;
    logic [SAMPLE_W-1:0]        p4_mean_reg;
    logic [IDX_W-1:0]           p4_idx_reg;
    logic                       p4_ok_reg;
    // stage 5: square ring read data back
    logic                       p5_valid_reg;
    logic [SQ_W-1:0]            p5_sq_reg;
    logic [WSUM_W-1:0]          p5_wsum_reg;
    logic [SAMPLE_W-1:0]        p5_mean_reg;
    logic                       p5_ok_reg;
    logic [SQ_W-1:0]            square_rd_reg;
    // output
    logic                       out_valid_reg;
    logic [WSUM_W-1:0]          out_wsum_reg;
    logic [SAMPLE_W-1:0]        out_mean_reg;
    logic [DSUM_W-1:0]          out_dsum_reg;

    sum_t                       old_sample;
    sum_t                       old_square;
    sum_t                       mean32;
    logic signed [SUM_W:0]      diff;
    logic [SUM_W:0]             abs_diff;
    logic [DEV_W-1:0]           dev_clamped;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign in_beat  = s_tvalid && adv;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DSUM_W - SAMPLE_W - WSUM_W){1'b0}},
                       out_dsum_reg, out_mean_reg, out_wsum_reg};

    // Sample ring: read old entry and write the new sample in the same cycle.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            sample_rd_reg               <= sample_ring[ring_index_reg];
            sample_ring[ring_index_reg] <= signed'(s_tdata);
        end
    end

    // Square ring: accessed at stage 4, so the earlier write to an entry always lands first.
    always_ff @(posedge aclk) begin
        if (adv && p4_valid_reg) begin
            square_rd_reg           <= square_ring[p4_idx_reg];
            square_ring[p4_idx_reg] <= p4_sq_reg;
        end
    end

    always_comb begin
        old_sample      = p1_ok_reg ? sum_t'(sample_rd_reg) : '0;
        sample_sum_next = window_update(sample_sum_reg, sum_t'(p1_sample_reg), old_sample);
    end

    always_comb begin
        mean32      = sample_sum_reg >>> WINDOW_LOG2;
        diff        = (SUM_W+1)'(p2_sample_reg) - (SUM_W+1)'(mean32);
        abs_diff    = diff[SUM_W] ? unsigned'(-diff) : unsigned'(diff);
        dev_clamped = (abs_diff > (SUM_W+1)'(DEV_LIMIT)) ? DEV_LIMIT : abs_diff[DEV_W-1:0];
    end

    always_comb begin
        old_square      = p5_ok_reg ? sum_t'({{(SUM_W-SQ_W){1'b0}}, square_rd_reg}) : '0;
        square_sum_next = window_update(square_sum_reg,
                                        sum_t'({{(SUM_W-SQ_W){1'b0}}, p5_sq_reg}), old_square);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_index_reg <= '0;
            filled_reg     <= 1'b0;
            sample_sum_reg <= '0;
            square_sum_reg <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            p4_valid_reg   <= 1'b0;
            p5_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (adv) begin
            if (in_beat) begin
                ring_index_reg <= ring_index_reg + 1'b1;
                if (ring_index_reg == IDX_W'(DEPTH - 1)) begin
                    filled_reg <= 1'b1;
                end
            end
            if (p1_valid_reg) begin
                sample_sum_reg <= sample_sum_next;
            end
            if (p5_valid_reg) begin
                square_sum_reg <= square_sum_next;
            end
            p1_valid_reg  <= in_beat;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            out_valid_reg <= p5_valid_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_sample_reg <= signed'(s_tdata);
            p1_idx_reg    <= ring_index_reg;
            p1_ok_reg     <= filled_reg;

            p2_sample_reg <= p1_sample_reg;
            p2_idx_reg    <= p1_idx_reg;
            p2_ok_reg     <= p1_ok_reg;

            p3_dev_reg    <= dev_clamped;
            p3_wsum_reg   <= sample_sum_reg[WSUM_W-1:0];
            p3_mean_reg   <= mean32[SAMPLE_W-1:0];
            p3_idx_reg    <= p2_idx_reg;
            p3_ok_reg     <= p2_ok_reg;

            p4_sq_reg     <= SQ_W'(p3_dev_reg) * SQ_W'(p3_dev_reg);
            p4_wsum_reg   <= p3_wsum_reg;
            p4_mean_reg   <= p3_mean_reg;
            p4_idx_reg    <= p3_idx_reg;
            p4_ok_reg     <= p3_ok_reg;

            p5_sq_reg     <= p4_sq_reg;
            p5_wsum_reg   <= p4_wsum_reg;
            p5_mean_reg   <= p4_mean_reg;
            p5_ok_reg     <= p4_ok_reg;

            out_wsum_reg  <= p5_wsum_reg;
            out_mean_reg  <= p5_mean_reg;
            out_dsum_reg  <= square_sum_next[DSUM_W-1:0];
        end
    end

    // Index moves by one per accepted beat and holds otherwise.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ring_index_reg == $past(ring_index_reg) + 1'b1)
        else $error("ring index did not advance on an accepted beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) |=> $stable(ring_index_reg))
        else $error("ring index moved without an accepted beat");

    // Once the ring has wrapped, every entry has been written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg |=> filled_reg)
        else $error("wrap flag cleared outside reset");

    // A stalled output freezes the pipeline and the running sums.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(sample_sum_reg) && $stable(square_sum_reg)
            && $stable(p1_valid_reg) && $stable(p5_valid_reg))
        else $error("pipeline moved during output stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        p3_valid_reg |-> p3_dev_reg <= DEV_LIMIT)
        else $error("deviation above clamp limit");

endmodule

// ----- bench/windowed_mean_and_rms_sum_checker.sv -----
// Stream checker: predicts window sum, mean and squared-deviation sum per sample beat.
`timescale 1ns / 100ps

module windowed_mean_and_rms_sum_checker #(
    parameter int WINDOW_LOG2 = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [wmrs_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [wmrs_pkg::M_TDATA_W-1:0]  m_tdata,   // [23:0] window_sum, [39:24] window_mean,
                                                       // [69:40] dev_square_sum, [71:70] zero
    output int                              fail_count,
    output int                              pending
);
    import wmrs_pkg::*;

    localparam int  DEPTH   = 1 << WINDOW_LOG2;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [WSUM_W-1:0]   window_sum;
        logic signed [SAMPLE_W-1:0] window_mean;
        logic [DSUM_W-1:0]          dev_square_sum;
    } window_stats_t;

    logic signed [SAMPLE_W-1:0] sample_hist [DEPTH];
    logic [SQ_W-1:0]            square_hist [DEPTH];
    logic signed [SUM_W-1:0]    level_acc;
    logic signed [SUM_W-1:0]    spread_acc;
    logic [WINDOW_LOG2-1:0]     slot;
    window_stats_t              stats_q [$];
    int                         errors = 0;

    function automatic logic signed [SUM_W-1:0] clip32(input longint v);
        if (v > S32_MAX) return S32_MAX[SUM_W-1:0];
        if (v < S32_MIN) return S32_MIN[SUM_W-1:0];
        return v[SUM_W-1:0];
    endfunction

    // Two clamped steps: add the newcomer, then drop the entry leaving the window.
    function automatic logic signed [SUM_W-1:0] slide(input logic signed [SUM_W-1:0] acc,
                                                      input longint add, input longint sub);
        logic signed [SUM_W-1:0] t;
        t = clip32(longint'(acc) + add);
        return clip32(longint'(t) - sub);
    endfunction

    task automatic predict_stats(input logic signed [SAMPLE_W-1:0] s);
        logic signed [SUM_W-1:0] mean32;
        longint                  dev;
        logic [SQ_W-1:0]         sq;
        window_stats_t           r;
        level_acc = slide(level_acc, longint'(s), longint'(sample_hist[slot]));
        sample_hist[slot] = s;
        mean32 = level_acc >>> WINDOW_LOG2;
        dev = longint'(s) - longint'(mean32);
        if (dev < 0) dev = -dev;
        if (dev > longint'(DEV_LIMIT)) dev = longint'(DEV_LIMIT);
        sq = SQ_W'(dev * dev);
        spread_acc = slide(spread_acc, longint'(sq), longint'(square_hist[slot]));
        square_hist[slot] = sq;
        slot = slot + 1'b1;
        r.window_sum     = level_acc[WSUM_W-1:0];
        r.window_mean    = mean32[SAMPLE_W-1:0];
        r.dev_square_sum = spread_acc[DSUM_W-1:0];
        stats_q.push_back(r);
    endtask

    task automatic check_stats(input logic [M_TDATA_W-1:0] d);
        window_stats_t              e;
        logic signed [WSUM_W-1:0]   got_sum;
        logic signed [SAMPLE_W-1:0] got_mean;
        logic [DSUM_W-1:0]          got_sq;
        got_sum  = d[23:0];
        got_mean = d[39:24];
        got_sq   = d[69:40];
        if (stats_q.size() == 0) begin
            $error("result beat with nothing expected: tdata %h", d);
            errors++;
            return;
        end
        e = stats_q.pop_front();
        if (got_sum !== e.window_sum) begin
            $error("window_sum: expected %0d, actual %0d", e.window_sum, got_sum);
            errors++;
        end
        if (got_mean !== e.window_mean) begin
            $error("window_mean: expected %0d, actual %0d", e.window_mean, got_mean);
            errors++;
        end
        if (got_sq !== e.dev_square_sum) begin
            $error("dev_square_sum: expected %0d, actual %0d", e.dev_square_sum, got_sq);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                sample_hist[i] = '0;
                square_hist[i] = '0;
            end
            level_acc  = '0;
            spread_acc = '0;
            slot       = '0;
            stats_q.delete();
        end else begin
            if (s_tvalid && s_tready) predict_stats($signed(s_tdata));
            if (m_tvalid && m_tready) check_stats(m_tdata);
        end
        fail_count <= errors;
        pending    <= stats_q.size();
    end

endmodule

// ----- bench/windowed_mean_and_rms_sum_tb.sv -----
// Top of the bench: clock, reset, sample stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module windowed_mean_and_rms_sum_tb;
    import wmrs_pkg::*;

    localparam int RANDOM_ITEMS = 650;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    fail_count;
    int                    pending;
    bit                    no_idle  = 1'b0;
    int                    sent     = 0;

    windowed_mean_and_rms_sum DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    windowed_mean_and_rms_sum_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_sample(input int v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SAMPLE_W'(v);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // Sender holds off until the checker has seen every result it expects.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Result side: a random stall before each beat, none during segments sent with no idle gaps.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    initial begin
        int directed [] = '{0, 32767, -32768, -1, 1, 32767, 32767, -32768, -32768,
                            2047, -2047, 2048, 100, 101, 99, 16384, -16384,
                            21845, -21846, 255, -256, 0, 0};
        int mode;
        int seg_len;
        int polarity;
        int level;
        int hold;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_sample(directed[i]);
        drain_results();

        while (sent < RANDOM_ITEMS + directed.size()) begin
            mode    = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 3) == 0);
            seg_len = (mode == 1) ? $urandom_range(40, 300) : $urandom_range(10, 80);
            polarity = $urandom_range(0, 2);
            level   = int'($urandom_range(0, 60000)) - 30000;
            hold    = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS + directed.size(); k++) begin
                case (mode)
                    0: begin
                        send_sample(int'($urandom_range(0, 65535)) - 32768);
                    end
                    1: begin
                        // full-scale runs push the window sum to its extremes
                        if (polarity == 0)
                            send_sample(32767);
                        else if (polarity == 1)
                            send_sample(-32768);
                        else
                            send_sample($urandom_range(0, 1) ? 32767 : -32768);
                    end
                    2: begin
                        // near a level, so the deviation mostly stays below the clamp
                        send_sample(clamp16(level + int'($urandom_range(0, 4000)) - 2000));
                    end
                    default: begin
                        send_sample(hold);
                    end
                endcase
            end
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
